FILE: rtl/kacc_pkg.sv
// Shared types, codes and constants of the keypad autorepeat and chord controller.
`default_nettype none
package kacc_pkg;

    localparam int DEF_BUTTON_COUNT = 19;
    localparam int ALTS             = 3;
    localparam int IDX_W            = 5;
    localparam int TOTAL_W          = 5;
    localparam int TIME_W           = 32;
    localparam int MS_W             = 16;
    localparam int SPEED_W          = 10;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int MS_PER_S         = 1000;
    localparam int LIMIT_W          = 26;

    localparam logic [MS_W-1:0]    RST_DELAY_MS   = 16'd500;
    localparam logic [MS_W-1:0]    RST_PERIOD_MS  = 16'd100;
    localparam logic [LIMIT_W-1:0] RST_IDLE_LIMIT = 26'd60000;

    typedef enum logic [1:0] {
        CMD_NONE        = 2'd0,
        CMD_DISPLAY_OFF = 2'd1,
        CMD_DISPLAY_ON  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DELAY  = 2'd1,
        PH_REPEAT = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY  = 3'd0,
        CFG_REPEAT_PERIOD = 3'd1,
        CFG_DISP_TIMEOUT  = 3'd2,
        CFG_LOW_CLOCK     = 3'd3,
        CFG_NORMAL_CLOCK  = 3'd4
    } t_cfg_idx;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/key_autorepeat_chord_controller_unit.sv
// Keypad controller with typematic autorepeat, chord matching and display idle timeout.
// A beat is held in the input register, its result in the output register; each button has its own
// repeat lane with a 32-bit compare. Throughput: one beat per cycle unless the output stalls.
// While a finished result waits to be taken, the input register holds one more beat, then stalls.
// Reset clears the held buttons, all repeat timing and the idle time, turns the display on
// and loads the register defaults; there is no clearing pass.
`default_nettype none
module key_autorepeat_chord_controller_unit #(
    parameter int BUTTON_COUNT = kacc_pkg::DEF_BUTTON_COUNT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kacc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kacc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic [kacc_pkg::TIME_W-1:0]       i_now_ms,
    input  wire logic [BUTTON_COUNT-1:0]           i_button_levels,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_main_a,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_modifier_a,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_main_b,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_modifier_b,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_main_c,
    input  wire logic [kacc_pkg::IDX_W-1:0]        i_modifier_c,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_chord_fired,
    output logic                                   o_display_is_on,
    output logic [1:0]                             o_display_command,
    output logic                                   o_clock_request_valid,
    output logic [kacc_pkg::SPEED_W-1:0]           o_clock_request_speed,
    output logic [BUTTON_COUNT-1:0]                o_held_mask,
    output logic [kacc_pkg::TOTAL_W-1:0]           o_held_total
);
    import kacc_pkg::*;

    localparam logic [IDX_W-1:0] ALONE_CODE = IDX_W'(BUTTON_COUNT);

    logic [MS_W-1:0]    r_delay_ms;
    logic [MS_W-1:0]    r_period_ms;
    logic [LIMIT_W-1:0] r_idle_limit;
    logic [SPEED_W-1:0] r_low_speed;
    logic [SPEED_W-1:0] r_normal_speed;

    logic                    r_in_valid;
    logic                    r_in_mode;
    logic [TIME_W-1:0]       r_in_now;
    logic [BUTTON_COUNT-1:0] r_in_levels;
    logic [IDX_W-1:0]        r_in_main [ALTS];
    logic [IDX_W-1:0]        r_in_mod  [ALTS];

    logic [BUTTON_COUNT-1:0] r_held;
    logic [TOTAL_W-1:0]      r_held_cnt;
    logic [TIME_W-1:0]       r_last_fire [BUTTON_COUNT];
    t_phase                  r_phase     [BUTTON_COUNT];
    logic                    r_display_on;
    logic [TIME_W-1:0]       r_idle_since;

    logic [BUTTON_COUNT-1:0] n_held;
    logic [TOTAL_W-1:0]      n_held_cnt;
    logic [TIME_W-1:0]       n_last_fire [BUTTON_COUNT];
    t_phase                  n_phase     [BUTTON_COUNT];
    logic                    n_display_on;
    logic [TIME_W-1:0]       n_idle_since;

    logic                    r_out_valid;
    logic                    r_out_fired;
    logic                    r_out_disp;
    t_cmd                    r_out_cmd;
    logic                    r_out_cval;
    logic [SPEED_W-1:0]      r_out_cspeed;
    logic                    n_out_fired;
    t_cmd                    n_out_cmd;
    logic                    n_out_cval;
    logic [SPEED_W-1:0]      n_out_cspeed;

    logic                    w_advance;
    logic [TOTAL_W-1:0]      w_level_cnt;
    logic [TIME_W-1:0]       w_idle_diff;
    logic                    w_match   [ALTS];
    logic                    w_want    [BUTTON_COUNT];
    logic [TIME_W-1:0]       w_diff    [BUTTON_COUNT];
    logic [MS_W-1:0]         w_thr     [BUTTON_COUNT];

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ms     <= RST_DELAY_MS;
            r_period_ms    <= RST_PERIOD_MS;
            r_idle_limit   <= RST_IDLE_LIMIT;
            r_low_speed    <= '0;
            r_normal_speed <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REPEAT_DELAY:  r_delay_ms     <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_period_ms    <= i_cfg_data;
                CFG_DISP_TIMEOUT:  r_idle_limit   <= LIMIT_W'(i_cfg_data) * LIMIT_W'(MS_PER_S);
                CFG_LOW_CLOCK:     r_low_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_NORMAL_CLOCK:  r_normal_speed <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_mode    <= i_mode;
            r_in_now     <= i_now_ms;
            r_in_levels  <= i_button_levels;
            r_in_main[0] <= i_main_a;
            r_in_mod[0]  <= i_modifier_a;
            r_in_main[1] <= i_main_b;
            r_in_mod[1]  <= i_modifier_b;
            r_in_main[2] <= i_main_c;
            r_in_mod[2]  <= i_modifier_c;
        end
    end

    always_comb begin
        w_level_cnt = '0;
        for (int j = 0; j < BUTTON_COUNT; j++) begin
            w_level_cnt = w_level_cnt + TOTAL_W'(r_in_levels[j]);
        end
        w_idle_diff = r_in_now - r_idle_since;

        for (int i = 0; i < ALTS; i++) begin
            w_match[i] = (r_in_mod[i] == ALONE_CODE) && (r_held_cnt == TOTAL_W'(1));
            for (int j = 0; j < BUTTON_COUNT; j++) begin
                if (r_in_mod[i] == IDX_W'(j) && r_held[j]) begin
                    w_match[i] = 1'b1;
                end
            end
        end

        for (int j = 0; j < BUTTON_COUNT; j++) begin
            w_want[j] = 1'b0;
            for (int i = 0; i < ALTS; i++) begin
                if (r_in_main[i] == IDX_W'(j) && w_match[i]) begin
                    w_want[j] = 1'b1;
                end
            end
            w_want[j] = w_want[j] && r_held[j];
            w_diff[j] = r_in_now - r_last_fire[j];
            case (r_phase[j])
                PH_IDLE:  w_thr[j] = '0;
                PH_DELAY: w_thr[j] = r_delay_ms;
                default:  w_thr[j] = r_period_ms;
            endcase
        end

        n_held       = r_held;
        n_held_cnt   = r_held_cnt;
        n_display_on = r_display_on;
        n_idle_since = r_idle_since;
        n_out_fired  = 1'b0;
        n_out_cmd    = CMD_NONE;
        n_out_cval   = 1'b0;
        n_out_cspeed = '0;
        for (int j = 0; j < BUTTON_COUNT; j++) begin
            n_last_fire[j] = r_last_fire[j];
            n_phase[j]     = r_phase[j];
        end

        if (r_in_mode == MODE_SCAN) begin
            n_held     = r_in_levels;
            n_held_cnt = w_level_cnt;
            for (int j = 0; j < BUTTON_COUNT; j++) begin
                if (!r_in_levels[j]) begin
                    n_last_fire[j] = '0;
                    n_phase[j]     = PH_IDLE;
                end
            end
            if (w_level_cnt == '0) begin
                if (w_idle_diff > TIME_W'(r_idle_limit) && r_display_on) begin
                    n_display_on = 1'b0;
                    n_out_cmd    = CMD_DISPLAY_OFF;
                    if (r_low_speed != '0) begin
                        n_out_cval   = 1'b1;
                        n_out_cspeed = r_low_speed;
                    end
                end
            end else begin
                if (!r_display_on) begin
                    n_display_on = 1'b1;
                    n_out_cmd    = CMD_DISPLAY_ON;
                    if (r_normal_speed != '0) begin
                        n_out_cval   = 1'b1;
                        n_out_cspeed = r_normal_speed;
                    end
                end
                n_idle_since = r_in_now;
            end
        end else begin
            for (int j = 0; j < BUTTON_COUNT; j++) begin
                if (w_want[j] && (w_diff[j] > TIME_W'(w_thr[j]))) begin
                    n_last_fire[j] = r_in_now;
                    n_phase[j]     = (r_phase[j] == PH_IDLE) ? PH_DELAY : PH_REPEAT;
                    n_out_fired    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_cnt   <= '0;
            r_display_on <= 1'b1;
            r_idle_since <= '0;
            r_out_valid  <= 1'b0;
            for (int j = 0; j < BUTTON_COUNT; j++) begin
                r_last_fire[j] <= '0;
                r_phase[j]     <= PH_IDLE;
            end
        end else begin
            if (w_advance) begin
                r_held       <= n_held;
                r_held_cnt   <= n_held_cnt;
                r_display_on <= n_display_on;
                r_idle_since <= n_idle_since;
                for (int j = 0; j < BUTTON_COUNT; j++) begin
                    r_last_fire[j] <= n_last_fire[j];
                    r_phase[j]     <= n_phase[j];
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_fired  <= n_out_fired;
            r_out_disp   <= n_display_on;
            r_out_cmd    <= n_out_cmd;
            r_out_cval   <= n_out_cval;
            r_out_cspeed <= n_out_cspeed;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_chord_fired         = r_out_fired;
    assign o_display_is_on       = r_out_disp;
    assign o_display_command     = r_out_cmd;
    assign o_clock_request_valid = r_out_cval;
    assign o_clock_request_speed = r_out_cspeed;
    assign o_held_mask           = r_held;
    assign o_held_total          = r_held_cnt;

endmodule
`default_nettype wire

FILE: rtl/kacc_checker.sv
// Port-level checker of the keypad autorepeat and chord controller, with its bind.
`default_nettype none
module kacc_checker #(
    parameter int BUTTON_COUNT = kacc_pkg::DEF_BUTTON_COUNT
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_chord_fired,
    input wire logic                          o_display_is_on,
    input wire logic [1:0]                    o_display_command,
    input wire logic                          o_clock_request_valid,
    input wire logic [kacc_pkg::SPEED_W-1:0]  o_clock_request_speed,
    input wire logic [BUTTON_COUNT-1:0]       o_held_mask,
    input wire logic [kacc_pkg::TOTAL_W-1:0]  o_held_total
);
    import kacc_pkg::*;

    a_cmd_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_display_command != CMD_NONE)
            |-> (o_display_is_on == (o_display_command == CMD_DISPLAY_ON)))
        else $error("Display command disagrees with the display state.");

    a_clock_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clock_request_valid
            |-> (o_clock_request_speed != '0) && (o_display_command != CMD_NONE))
        else $error("Clock request without a display change or with zero speed.");

    a_fire_is_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_chord_fired |-> (o_display_command == CMD_NONE))
        else $error("Chord fired on a beat that also switched the display.");

    a_total_counts_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_held_mask) == int'(o_held_total)))
        else $error("Held total does not match the held mask.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_display_command)
            && $stable(o_chord_fired) && $stable(o_held_mask))
        else $error("Result changed while stalled.");

endmodule

bind key_autorepeat_chord_controller_unit kacc_checker #(
    .BUTTON_COUNT(BUTTON_COUNT)
) u_kacc_checker (.*);
`default_nettype wire

FILE: bench/tb_key_autorepeat_chord_controller_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keypad autorepeat, chord and display timeout controller.
module tb_key_autorepeat_chord_controller_unit;
    import kacc_pkg::*;

    localparam int NBTN = DEF_BUTTON_COUNT;
    localparam logic [IDX_W-1:0] ALONE = IDX_W'(NBTN);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int RANDOM_BEATS = 1130;
    localparam int PHASES = 5;

    typedef struct {
        logic              mode;
        logic [TIME_W-1:0] now;
        logic [NBTN-1:0]   levels;
        logic [IDX_W-1:0]  main_idx [ALTS];
        logic [IDX_W-1:0]  mod_idx [ALTS];
    } t_key_beat;

    typedef struct {
        logic               fired;
        logic               disp_on;
        logic [1:0]         cmd;
        logic               clk_valid;
        logic [SPEED_W-1:0] clk_speed;
        logic [NBTN-1:0]    held;
        logic [TOTAL_W-1:0] total;
    } t_key_result;

    class keypad_tracker;
        logic [MS_W-1:0]    delay_ms;
        logic [MS_W-1:0]    period_ms;
        logic [MS_W-1:0]    timeout_s;
        logic [SPEED_W-1:0] low_speed;
        logic [SPEED_W-1:0] normal_speed;
        logic [NBTN-1:0]    held;
        logic [TOTAL_W-1:0] held_cnt;
        logic [TIME_W-1:0]  fired_at [NBTN];
        t_phase             phase [NBTN];
        logic               disp_on;
        logic [TIME_W-1:0]  idle_start;
        t_key_result        due_results [$];
        int                 failures;

        function new();
            int k;
            delay_ms     = RST_DELAY_MS;
            period_ms    = RST_PERIOD_MS;
            timeout_s    = MS_W'(RST_IDLE_LIMIT / MS_PER_S);
            low_speed    = '0;
            normal_speed = '0;
            held         = '0;
            held_cnt     = '0;
            for (k = 0; k < NBTN; k++) begin
                fired_at[k] = '0;
                phase[k]    = PH_IDLE;
            end
            disp_on    = 1'b1;
            idle_start = '0;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REPEAT_DELAY:  delay_ms = data;
                CFG_REPEAT_PERIOD: period_ms = data;
                CFG_DISP_TIMEOUT:  timeout_s = data;
                CFG_LOW_CLOCK:     low_speed = data[SPEED_W-1:0];
                CFG_NORMAL_CLOCK:  normal_speed = data[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function bit pressed(logic [IDX_W-1:0] idx);
            if (idx >= NBTN) return 1'b0;
            return held[idx];
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void accept_beat(t_key_beat b);
            t_key_result       want;
            logic [TIME_W-1:0] span;
            logic [TIME_W-1:0] thr;
            logic [TIME_W-1:0] limit;
            logic [IDX_W-1:0]  m;
            logic [IDX_W-1:0]  md;
            int                k;
            want = '{default: '0};
            if (b.mode == MODE_SCAN) begin
                held     = b.levels;
                held_cnt = '0;
                for (k = 0; k < NBTN; k++) begin
                    if (b.levels[k]) begin
                        held_cnt++;
                    end else begin
                        fired_at[k] = '0;
                        phase[k]    = PH_IDLE;
                    end
                end
                if (held_cnt == 0) begin
                    span  = b.now - idle_start;
                    limit = TIME_W'(timeout_s) * MS_PER_S;
                    if (span > limit && disp_on) begin
                        disp_on  = 1'b0;
                        want.cmd = CMD_DISPLAY_OFF;
                        if (low_speed != 0) begin
                            want.clk_valid = 1'b1;
                            want.clk_speed = low_speed;
                        end
                    end
                end else begin
                    if (!disp_on) begin
                        if (normal_speed != 0) begin
                            want.clk_valid = 1'b1;
                            want.clk_speed = normal_speed;
                        end
                        disp_on  = 1'b1;
                        want.cmd = CMD_DISPLAY_ON;
                    end
                    idle_start = b.now;
                end
            end else begin
                for (k = 0; k < ALTS; k++) begin
                    m  = b.main_idx[k];
                    md = b.mod_idx[k];
                    if (pressed(m) && ((md == ALONE && held_cnt == 1) || pressed(md))) begin
                        case (phase[m])
                            PH_IDLE:  thr = '0;
                            PH_DELAY: thr = TIME_W'(delay_ms);
                            default:  thr = TIME_W'(period_ms);
                        endcase
                        span = b.now - fired_at[m];
                        if (span > thr) begin
                            fired_at[m] = b.now;
                            phase[m]    = (phase[m] == PH_IDLE) ? PH_DELAY : PH_REPEAT;
                            want.fired  = 1'b1;
                        end
                    end
                end
            end
            want.disp_on = disp_on;
            want.held    = held;
            want.total   = held_cnt;
            due_results.push_back(want);
        endfunction

        task report(string msg);
            failures++;
            if (failures <= 50) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_beat(t_key_result got);
            t_key_result want;
            if (due_results.size() == 0) begin
                report("result beat with no expectation waiting");
                return;
            end
            want = due_results.pop_front();
            if (got.fired !== want.fired)
                report($sformatf("chord_fired %0h, expected %0h", got.fired, want.fired));
            if (got.disp_on !== want.disp_on)
                report($sformatf("display_is_on %0h, expected %0h", got.disp_on, want.disp_on));
            if (got.cmd !== want.cmd)
                report($sformatf("display_command %0h, expected %0h", got.cmd, want.cmd));
            if (got.clk_valid !== want.clk_valid)
                report($sformatf("clock_request_valid %0h, expected %0h",
                                 got.clk_valid, want.clk_valid));
            if (got.clk_speed !== want.clk_speed)
                report($sformatf("clock_request_speed %0h, expected %0h",
                                 got.clk_speed, want.clk_speed));
            if (got.held !== want.held)
                report($sformatf("held_mask %0h, expected %0h", got.held, want.held));
            if (got.total !== want.total)
                report($sformatf("held_total %0h, expected %0h", got.total, want.total));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = MODE_SCAN;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic [NBTN-1:0]       i_button_levels = '0;
    logic [IDX_W-1:0]      i_main_a = '0;
    logic [IDX_W-1:0]      i_modifier_a = '0;
    logic [IDX_W-1:0]      i_main_b = '0;
    logic [IDX_W-1:0]      i_modifier_b = '0;
    logic [IDX_W-1:0]      i_main_c = '0;
    logic [IDX_W-1:0]      i_modifier_c = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_chord_fired;
    logic                  o_display_is_on;
    logic [1:0]            o_display_command;
    logic                  o_clock_request_valid;
    logic [SPEED_W-1:0]    o_clock_request_speed;
    logic [NBTN-1:0]       o_held_mask;
    logic [TOTAL_W-1:0]    o_held_total;

    keypad_tracker     board = new();
    int                sent = 0;
    bit                send_calm = 1'b0;
    bit                take_calm = 1'b0;
    int                stall_cycles = 0;
    int unsigned       cycle_count = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    key_autorepeat_chord_controller_unit #(
        .BUTTON_COUNT(NBTN)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_mode               (i_mode),
        .i_now_ms             (i_now_ms),
        .i_button_levels      (i_button_levels),
        .i_main_a             (i_main_a),
        .i_modifier_a         (i_modifier_a),
        .i_main_b             (i_main_b),
        .i_modifier_b         (i_modifier_b),
        .i_main_c             (i_main_c),
        .i_modifier_c         (i_modifier_c),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_chord_fired        (o_chord_fired),
        .o_display_is_on      (o_display_is_on),
        .o_display_command    (o_display_command),
        .o_clock_request_valid(o_clock_request_valid),
        .o_clock_request_speed(o_clock_request_speed),
        .o_held_mask          (o_held_mask),
        .o_held_total         (o_held_total)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_key_beat random_beat();
        t_key_beat b;
        int k;
        b.mode   = 1'($urandom_range(0, 1));
        b.now    = $urandom();
        b.levels = NBTN'($urandom());
        for (k = 0; k < ALTS; k++) begin
            b.main_idx[k] = IDX_W'($urandom());
            b.mod_idx[k]  = IDX_W'($urandom());
        end
        return b;
    endfunction

    function automatic logic [TIME_W-1:0] time_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 40);
            4, 5: return TIME_W'(board.delay_ms) + $urandom_range(0, 2) - 32'd1;
            6: return TIME_W'(board.period_ms) + $urandom_range(0, 2) - 32'd1;
            7: return TIME_W'(board.timeout_s) * MS_PER_S + $urandom_range(0, 2) - 32'd1;
            8: return $urandom();
            default: return $urandom_range(0, 1);
        endcase
    endfunction

    function automatic logic [NBTN-1:0] pick_pattern();
        logic [NBTN-1:0] p;
        p = '0;
        case ($urandom_range(0, 7))
            0, 1: p[$urandom_range(0, NBTN - 1)] = 1'b1;
            2, 3: begin
                p[$urandom_range(0, NBTN - 1)] = 1'b1;
                p[$urandom_range(0, NBTN - 1)] = 1'b1;
            end
            4: begin
                p[$urandom_range(0, NBTN - 1)] = 1'b1;
                p[$urandom_range(0, NBTN - 1)] = 1'b1;
                p[$urandom_range(0, NBTN - 1)] = 1'b1;
            end
            5: p = NBTN'($urandom());
            6: p = '1;
            default: p = NBTN'($urandom() & $urandom());
        endcase
        return p;
    endfunction

    function automatic logic [IDX_W-1:0] held_index(logic [NBTN-1:0] pat);
        int k;
        if (pat == 0) return IDX_W'($urandom_range(0, NBTN - 1));
        do k = $urandom_range(0, NBTN - 1); while (!pat[k]);
        return IDX_W'(k);
    endfunction

    task automatic push_beat(input t_key_beat b);
        int gap;
        if (sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode          <= b.mode;
        i_now_ms        <= b.now;
        i_button_levels <= b.levels;
        i_main_a        <= b.main_idx[0];
        i_modifier_a    <= b.mod_idx[0];
        i_main_b        <= b.main_idx[1];
        i_modifier_b    <= b.mod_idx[1];
        i_main_c        <= b.main_idx[2];
        i_modifier_c    <= b.mod_idx[2];
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        board.accept_beat(b);
        sent++;
    endtask

    task automatic scan_at(input logic [TIME_W-1:0] t, input logic [NBTN-1:0] lv);
        t_key_beat b;
        b        = random_beat();
        b.mode   = MODE_SCAN;
        b.now    = t;
        b.levels = lv;
        push_beat(b);
    endtask

    task automatic query_at(input logic [TIME_W-1:0] t,
                            input logic [IDX_W-1:0] m0, d0, m1, d1, m2, d2);
        t_key_beat b;
        b             = random_beat();
        b.mode        = MODE_QUERY;
        b.now         = t;
        b.main_idx[0] = m0;
        b.mod_idx[0]  = d0;
        b.main_idx[1] = m1;
        b.mod_idx[1]  = d1;
        b.main_idx[2] = m2;
        b.mod_idx[2]  = d2;
        push_beat(b);
    endtask

    task automatic scan_later(input logic [TIME_W-1:0] delta, input logic [NBTN-1:0] lv);
        clock_ms = clock_ms + delta;
        scan_at(clock_ms, lv);
    endtask

    task automatic ask_chord(input logic [NBTN-1:0] pat);
        logic [IDX_W-1:0] m [ALTS];
        logic [IDX_W-1:0] md [ALTS];
        int k;
        for (k = 0; k < ALTS; k++) begin
            if ($urandom_range(0, 7) == 0) m[k] = IDX_W'($urandom());
            else m[k] = held_index(pat);
            case ($urandom_range(0, 9))
                0, 1, 2: md[k] = ALONE;
                3, 4, 5, 6: md[k] = held_index(pat);
                default: md[k] = IDX_W'($urandom());
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            k     = $urandom_range(1, ALTS - 1);
            m[k]  = m[0];
            md[k] = md[0];
        end
        clock_ms = clock_ms + time_step();
        query_at(clock_ms, m[0], md[0], m[1], md[1], m[2], md[2]);
    endtask

    task automatic run_session();
        logic [NBTN-1:0] pat;
        t_key_beat       b;
        int              kind;
        int              n;
        int              k;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            pat = pick_pattern();
            scan_later(time_step(), pat);
            n = $urandom_range(2, 10);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 6) == 0) scan_later(time_step(), pat);
                else ask_chord(pat);
            end
            case ($urandom_range(0, 2))
                0: scan_later(time_step(), '0);
                1: scan_later(time_step(), pat & NBTN'($urandom()));
                default: ;
            endcase
        end else if (kind < 17) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 1) == 0)
                    scan_later(TIME_W'(board.timeout_s) * MS_PER_S
                               + $urandom_range(0, 2) - 32'd1, '0);
                else
                    scan_later(time_step(), '0);
            end
            scan_later(time_step(), pick_pattern());
        end else begin
            b = random_beat();
            if ($urandom_range(0, 1) == 0) clock_ms = b.now;
            push_beat(b);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] dly, per, tmo, lo, nrm);
        int k;
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_REPEAT_PERIOD, per);
        write_reg(CFG_DISP_TIMEOUT, tmo);
        for (k = 0; k < 3; k++) write_reg(CFG_IDX_W'(CFG_SPARE + k), CFG_DATA_W'($urandom()));
        write_reg(CFG_LOW_CLOCK, lo);
        write_reg(CFG_NORMAL_CLOCK, nrm);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : result_sink
        t_key_result got;
        int gap;
        int taken;
        taken = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_cycles) @(posedge i_clk);
                stall_cycles = 0;
            end else begin
                if (taken % 48 == 0) take_calm = ($urandom_range(0, 3) == 0);
                gap = take_calm ? 0 : $urandom_range(0, 14);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.fired     = o_chord_fired;
            got.disp_on   = o_display_is_on;
            got.cmd       = o_display_command;
            got.clk_valid = o_clock_request_valid;
            got.clk_speed = o_clock_request_speed;
            got.held      = o_held_mask;
            got.total     = o_held_total;
            board.check_beat(got);
            taken++;
        end
    end

    initial begin : stimulus
        int ph;
        int goal;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: idle timeout edges, typematic timing, alone code, time wrap.
        query_at(32'd5, 5'd0, ALONE, 5'd18, 5'd0, 5'd31, 5'd31);
        scan_at(32'd10, '0);
        scan_at(32'd60000, '0);
        scan_at(32'd60001, '0);
        scan_at(32'd70000, '0);
        scan_at(32'd70010, NBTN'(1));
        query_at(32'd70011, 5'd0, ALONE, 5'd0, ALONE, 5'd0, ALONE);
        query_at(32'd70511, 5'd0, ALONE, 5'd1, ALONE, 5'd31, ALONE);
        query_at(32'd70512, 5'd0, ALONE, 5'd19, 5'd0, 5'd20, ALONE);
        query_at(32'd70612, 5'd0, ALONE, 5'd0, 5'd0, 5'd0, 5'd24);
        query_at(32'd70613, 5'd0, ALONE, 5'd0, ALONE, 5'd0, ALONE);
        scan_at(32'd70700, '1);
        query_at(32'd70701, 5'd18, 5'd0, 5'd0, ALONE, 5'd31, ALONE);
        query_at(32'd70702, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, ALONE);
        scan_at(32'd70800, NBTN'(1) << 18);
        query_at(32'd70801, 5'd18, ALONE, 5'd18, 5'd17, 5'd18, 5'd25);
        query_at(32'd71202, 5'd18, 5'd17, 5'd18, 5'd25, 5'd18, ALONE);
        scan_at(32'hFFFF_FFF0, NBTN'(1) << 3);
        query_at(32'hFFFF_FFF5, 5'd3, ALONE, 5'd19, ALONE, 5'd31, 5'd3);
        query_at(32'h0000_01F0, 5'd3, ALONE, 5'd3, 5'd3, 5'd16, 5'd3);
        scan_at(32'h0000_0200, '0);
        scan_at(32'h0000_0300, NBTN'(1) << 2);
        query_at(32'd0, 5'd2, ALONE, 5'd16, 5'd2, 5'd2, 5'd16);

        clock_ms = $urandom();
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: program_regs(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1);
                1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
                2: program_regs(16'd20, 16'd5, 16'd1, 16'($urandom_range(1, 1023)),
                                16'($urandom_range(1, 1023)));
                3: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                16'($urandom()), 16'($urandom()));
                default: program_regs(16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)),
                                      16'($urandom_range(0, 5)), 16'($urandom_range(0, 3)),
                                      16'($urandom_range(0, 1023)));
            endcase
            if (ph == 1) begin
                // The sink holds off while beats keep coming, so the block backs up.
                stall_cycles = 300;
                send_calm    = 1'b1;
            end
            goal = sent + RANDOM_BEATS / PHASES;
            while (sent < goal) begin
                run_session();
                if ($urandom_range(0, 63) == 0) settle();
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        if (board.pending() != 0) board.report("expected results left over at the end");
        if (board.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
